/* hw/rtl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked property with synchronous reset gating
`define ESPH_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
   else $error("esph assertion failed");

// implication form
`define ESPH_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
   else $error("esph assertion failed");

`endif

/* hw/rtl/esph_pkg.sv */
// ----------------------------------------------------------------------------
// esph_pkg
// shared constants and types of the transverse spherocity core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package esph_pkg;

   localparam int MaxTracks = 256;
   localparam int IdxW      = $clog2(MaxTracks);
   localparam int CntW      = IdxW + 1;

   localparam logic [31:0] SinC1 = 32'd421657428;
   localparam logic [31:0] SinC3 = 32'd173399667;
   localparam logic [31:0] SinC5 = 32'd21392327;
   localparam logic [31:0] SinC7 = 32'd1256749;
   localparam logic [31:0] SinC9 = 32'd43068;
   localparam logic [17:0] Pi2Over4 = 18'd161704;

   localparam logic [1:0] RegPtCut     = 2'd0;
   localparam logic [1:0] RegEtaCut    = 2'd1;
   localparam logic [1:0] RegMinTracks = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE, ST_RD_I, ST_LD_I, ST_RD_J, ST_LD_J, ST_MSQ, ST_H9, ST_H7, ST_H5,
      ST_H3, ST_H1, ST_TERM, ST_ACC, ST_CMP, ST_DCHK, ST_DIV, ST_SQR, ST_SCL,
      ST_RND, ST_RESULT
   } state_type;

endpackage

/* hw/rtl/event_transverse_spherocity_core.sv */
// ----------------------------------------------------------------------------
// event_transverse_spherocity_core
// transverse spherocity of one event from a stream of tracks
// ----------------------------------------------------------------------------
// Tracks are taken one per cycle while the event is open. After the track
// marked tlast, if enough tracks were kept and their pt sum is nonzero, the core
// walks all kept track pairs with one shared multiplier: each pair runs through
// a store read, the folded sine polynomial and the pt weighting, and the ratio
// takes a 16-step serial divider. No track is taken until the result transfer
// completes.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module event_transverse_spherocity_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // track_pt[15:0], track_eta[31:16], track_phi[47:32], track_charge[49:48]
   input  logic [55:0] req_tdata,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // spherocity[15:0], kept_tracks[24:16], pt_total[48:25],
   // event_valid[49], track_overflow[50]
   output logic [55:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CW = esph_pkg::CntW;
   localparam int IW = esph_pkg::IdxW;

   esph_pkg::state_type state_ff, state_in;

   logic [15:0] pt_cut_ff;
   logic [14:0] eta_cut_ff;
   logic [8:0]  min_tracks_ff;

   logic [CW-1:0] kept_ff, kept_in, i_ff, i_in, j_ff, j_in;
   logic [23:0]   ptsum_ff, ptsum_in, acc_ff, acc_in, min_ff, min_in;
   logic          ovf_ff, ovf_in;
   logic [15:0]   phi_i_ff, phi_i_in, pt_j_ff, pt_j_in, sph_ff, sph_in;
   logic [14:0]   d_ff, d_in, u2_ff, u2_in;

   logic [31:0] mul_a;
   logic [17:0] mul_b;
   logic [49:0] prod_ff;
   logic        div_start, div_done;
   logic [15:0] div_q;

   logic        ram_we;
   logic [31:0] ram_rdata;

   logic [15:0] in_pt, in_eta, in_phi;
   logic [1:0]  in_chg;
   logic [16:0] eta_mag;
   logic        pass, req_xfer, rsp_xfer, csr_wr;
   logic [24:0] sum_wide;
   logic [15:0] dphi, dfold;
   logic [31:0] p_next;
   logic [26:0] s_wide;
   logic [16:0] s_val;
   logic [50:0] rnd_wide;

   assign in_pt  = req_tdata[15:0];
   assign in_eta = req_tdata[31:16];
   assign in_phi = req_tdata[47:32];
   assign in_chg = req_tdata[49:48];
   assign eta_mag = in_eta[15] ? (17'h10000 - {1'b0, in_eta}) : {1'b0, in_eta};
   assign pass = (in_chg != 2'b00) && (in_pt >= pt_cut_ff) &&
                 (eta_mag <= {2'b0, eta_cut_ff});

   assign req_tready = (state_ff == esph_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == esph_pkg::ST_RESULT);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = {5'b0, ovf_ff, (kept_ff >= min_tracks_ff), ptsum_ff,
                        kept_ff, sph_ff};

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_paddr[3:2])
         esph_pkg::RegPtCut:     csr_prdata = {16'b0, pt_cut_ff};
         esph_pkg::RegEtaCut:    csr_prdata = {17'b0, eta_cut_ff};
         esph_pkg::RegMinTracks: csr_prdata = {23'b0, min_tracks_ff};
         default:                csr_prdata = '0;
      endcase
   end

   assign ram_we   = req_xfer && pass && (kept_ff < CW'(esph_pkg::MaxTracks));
   assign sum_wide = {1'b0, ptsum_ff} + {9'b0, in_pt};

   esph_ram #(.WIDTH(32), .DEPTH(esph_pkg::MaxTracks)) u_store (
      .clock    (clock),
      .we       (ram_we),
      .waddr    (kept_ff[IW-1:0]),
      .wdata    ({in_phi, in_pt}),
      .raddr    ((state_ff == esph_pkg::ST_RD_I) ? i_ff[IW-1:0] : j_ff[IW-1:0]),
      .rdata_ff (ram_rdata)
   );

   esph_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   esph_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num     (min_ff),
      .den     (ptsum_ff),
      .done_ff (div_done),
      .quot_ff (div_q)
   );

   assign dphi     = ram_rdata[31:16] - phi_i_ff;
   assign dfold    = ({1'b0, dphi[14:0]} > 16'h4000) ? (16'h8000 - {1'b0, dphi[14:0]})
                                                     : {1'b0, dphi[14:0]};
   assign s_wide   = 27'(({7'b0, prod_ff[42:0]} + 50'h2000000) >> 26);
   assign s_val    = (s_wide > 27'd65536) ? 17'd65536 : s_wide[16:0];
   assign rnd_wide = {1'b0, prod_ff} + 51'h80000000;

   always_comb begin
      state_in  = state_ff;
      kept_in   = kept_ff;
      ptsum_in  = ptsum_ff;
      ovf_in    = ovf_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      acc_in    = acc_ff;
      min_in    = min_ff;
      phi_i_in  = phi_i_ff;
      pt_j_in   = pt_j_ff;
      d_in      = d_ff;
      u2_in     = u2_ff;
      sph_in    = sph_ff;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      p_next    = '0;
      case (state_ff)
         esph_pkg::ST_IDLE: begin
            if (req_xfer) begin
               if (pass) begin
                  if (ram_we) begin
                     kept_in  = kept_ff + CW'(1);
                     ptsum_in = sum_wide[24] ? 24'hFFFFFF : sum_wide[23:0];
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               if (req_tlast) begin
                  state_in = esph_pkg::ST_DCHK;
                  i_in     = '0;
                  min_in   = '1;
                  sph_in   = '0;
                  if ((kept_in >= min_tracks_ff) && (ptsum_in != 24'd0)) begin
                     state_in = esph_pkg::ST_RD_I;
                  end else begin
                     state_in = esph_pkg::ST_RESULT;
                  end
               end
            end
         end
         esph_pkg::ST_RD_I: state_in = esph_pkg::ST_LD_I;
         esph_pkg::ST_LD_I: begin
            phi_i_in = ram_rdata[31:16];
            j_in     = '0;
            acc_in   = '0;
            state_in = esph_pkg::ST_RD_J;
         end
         esph_pkg::ST_RD_J: state_in = esph_pkg::ST_LD_J;
         esph_pkg::ST_LD_J: begin
            pt_j_in  = ram_rdata[15:0];
            d_in     = dfold[14:0];
            state_in = esph_pkg::ST_MSQ;
         end
         esph_pkg::ST_MSQ: begin
            mul_a    = {17'b0, d_ff};
            mul_b    = {3'b0, d_ff};
            state_in = esph_pkg::ST_H9;
         end
         esph_pkg::ST_H9: begin
            u2_in    = prod_ff[28:14];
            mul_a    = esph_pkg::SinC9;
            mul_b    = {3'b0, prod_ff[28:14]};
            state_in = esph_pkg::ST_H7;
         end
         esph_pkg::ST_H7: begin
            p_next   = esph_pkg::SinC7 - prod_ff[45:14];
            mul_a    = p_next;
            mul_b    = {3'b0, u2_ff};
            state_in = esph_pkg::ST_H5;
         end
         esph_pkg::ST_H5: begin
            p_next   = esph_pkg::SinC5 - prod_ff[45:14];
            mul_a    = p_next;
            mul_b    = {3'b0, u2_ff};
            state_in = esph_pkg::ST_H3;
         end
         esph_pkg::ST_H3: begin
            p_next   = esph_pkg::SinC3 - prod_ff[45:14];
            mul_a    = p_next;
            mul_b    = {3'b0, u2_ff};
            state_in = esph_pkg::ST_H1;
         end
         esph_pkg::ST_H1: begin
            p_next   = esph_pkg::SinC1 - prod_ff[45:14];
            mul_a    = p_next;
            mul_b    = {3'b0, d_ff};
            state_in = esph_pkg::ST_TERM;
         end
         esph_pkg::ST_TERM: begin
            mul_a    = {15'b0, s_val};
            mul_b    = {2'b0, pt_j_ff};
            state_in = esph_pkg::ST_ACC;
         end
         esph_pkg::ST_ACC: begin
            acc_in = acc_ff + {8'b0, 16'(({1'b0, prod_ff} + 51'd32768) >> 16)};
            j_in   = j_ff + CW'(1);
            state_in = (j_in == kept_ff) ? esph_pkg::ST_CMP : esph_pkg::ST_RD_J;
         end
         esph_pkg::ST_CMP: begin
            if (acc_ff < min_ff) begin
               min_in = acc_ff;
            end
            i_in     = i_ff + CW'(1);
            state_in = (i_in == kept_ff) ? esph_pkg::ST_DCHK : esph_pkg::ST_RD_I;
         end
         esph_pkg::ST_DCHK: begin
            if (min_ff >= ptsum_ff) begin
               sph_in   = 16'hFFFF;
               state_in = esph_pkg::ST_RESULT;
            end else begin
               div_start = 1'b1;
               state_in  = esph_pkg::ST_DIV;
            end
         end
         esph_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = esph_pkg::ST_SQR;
            end
         end
         esph_pkg::ST_SQR: begin
            mul_a    = {16'b0, div_q};
            mul_b    = {2'b0, div_q};
            state_in = esph_pkg::ST_SCL;
         end
         esph_pkg::ST_SCL: begin
            mul_a    = prod_ff[31:0];
            mul_b    = esph_pkg::Pi2Over4;
            state_in = esph_pkg::ST_RND;
         end
         esph_pkg::ST_RND: begin
            sph_in   = (rnd_wide[50:32] > 19'd65535) ? 16'hFFFF : rnd_wide[47:32];
            state_in = esph_pkg::ST_RESULT;
         end
         esph_pkg::ST_RESULT: begin
            if (rsp_xfer) begin
               kept_in  = '0;
               ptsum_in = '0;
               ovf_in   = 1'b0;
               min_in   = '1;
               state_in = esph_pkg::ST_IDLE;
            end
         end
         default: state_in = esph_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= esph_pkg::ST_IDLE;
         pt_cut_ff     <= 16'd128;
         eta_cut_ff    <= 15'd3277;
         min_tracks_ff <= 9'd3;
         kept_ff       <= '0;
         ptsum_ff      <= '0;
         ovf_ff        <= 1'b0;
         i_ff          <= '0;
         j_ff          <= '0;
         min_ff        <= '1;
      end else begin
         state_ff <= state_in;
         kept_ff  <= kept_in;
         ptsum_ff <= ptsum_in;
         ovf_ff   <= ovf_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         min_ff   <= min_in;
         if (csr_wr) begin
            case (csr_paddr[3:2])
               esph_pkg::RegPtCut:     pt_cut_ff     <= csr_pwdata[15:0];
               esph_pkg::RegEtaCut:    eta_cut_ff    <= csr_pwdata[14:0];
               esph_pkg::RegMinTracks: min_tracks_ff <= csr_pwdata[8:0];
               default: ;
            endcase
         end
      end
      acc_ff   <= acc_in;
      phi_i_ff <= phi_i_in;
      pt_j_ff  <= pt_j_in;
      d_ff     <= d_in;
      u2_ff    <= u2_in;
      sph_ff   <= sph_in;
   end

   `ESPH_ASSERT(a_no_overlap, clock, reset, !(req_tready && rsp_tvalid))
   `ESPH_ASSERT(a_kept_range, clock, reset, kept_ff <= CW'(esph_pkg::MaxTracks))
   `ESPH_ASSERT_IMP(a_div_owner, clock, reset, div_done, state_ff == esph_pkg::ST_DIV)

endmodule

/* hw/rtl/esph_ram.sv */
// ----------------------------------------------------------------------------
// esph_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module esph_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

endmodule

/* hw/rtl/esph_mul.sv */
// ----------------------------------------------------------------------------
// esph_mul
// shared 32x18 unsigned multiplier with registered product
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module esph_mul (
   input  logic        clock,
   input  logic [31:0] mul_a,
   input  logic [17:0] mul_b,
   output logic [49:0] prod_ff
);

   logic [49:0] prod_in;

   assign prod_in = {18'b0, mul_a} * {32'b0, mul_b};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

/* hw/rtl/esph_div.sv */
// ----------------------------------------------------------------------------
// esph_div
// restoring divider, 16 fraction bits of num/den for num < den
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module esph_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [23:0] num,
   input  logic [23:0] den,
   output logic        done_ff,
   output logic [15:0] quot_ff
);

   logic [24:0] rem_ff, rem_in;
   logic [15:0] quot_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_in;
   logic [24:0] shifted;

   assign shifted = {rem_ff[23:0], 1'b0};

   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = {1'b0, num};
         quot_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den}) begin
            rem_in  = shifted - {1'b0, den};
            quot_in = {quot_ff[14:0], 1'b1};
         end else begin
            rem_in  = shifted;
            quot_in = {quot_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

endmodule
